[hdl/srle_pkg.sv]
// Shared types, character codes and helpers for the serial receive line editor.
// Used by the line store, the top level and the testbench.
package srle_pkg;

   localparam int LINE_MAX_DEF = 64;

   localparam logic [7:0] CH_NUL   = 8'h00;
   localparam logic [7:0] CH_BS    = 8'h08;
   localparam logic [7:0] CH_LF    = 8'h0A;
   localparam logic [7:0] CH_CR    = 8'h0D;
   localparam logic [7:0] PRINT_LO = 8'h20;
   localparam logic [7:0] PRINT_HI = 8'h7E;

   // Control of the line store: write and read enables and the write data.
   typedef struct packed {
      logic       wr_en;
      logic       rd_en;
      logic [7:0] wr_data;
   } store_ctl_type;

   function automatic logic is_printable(input logic [7:0] c);
      logic res;
      res = (c >= PRINT_LO) && (c <= PRINT_HI);
      return res;
   endfunction

endpackage

[hdl/srle_ifs.sv]
// Valid/ready channel interfaces for received bytes and line results.
// No dependencies.
interface srle_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] rx_byte;
   logic       rx_error;

   modport source (output valid, output rx_byte, output rx_error, input ready);
   modport sink   (input valid, input rx_byte, input rx_error, output ready);
endinterface

interface srle_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] line_char;
   logic       line_last;
   logic       line_empty;
   logic       line_truncated;

   modport source (output valid, output line_char, output line_last, output line_empty,
                   output line_truncated, input ready);
   modport sink   (input valid, input line_char, input line_last, input line_empty,
                   input line_truncated, output ready);
endinterface

[hdl/srle_store.sv]
// Line store: single-port-write, single-port-read synchronous memory with a registered read.
// Depends on srle_pkg for the control struct.
module srle_store #(
   parameter int DEPTH  = srle_pkg::LINE_MAX_DEF,
   parameter int ADDR_W = 6
) (
   input  logic                  clock,
   input  srle_pkg::store_ctl_type ctl,
   input  logic [ADDR_W-1:0]     wr_addr,
   input  logic [ADDR_W-1:0]     rd_addr,
   output logic [7:0]            rd_data
);

   logic [7:0] mem [DEPTH];
   logic [7:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (ctl.wr_en) begin
         mem[wr_addr] <= ctl.wr_data;
      end
      if (ctl.rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[hdl/serial_rx_line_editor_core.sv]
// Top level of the serial receive line editor: editing control and line emission.
// Depends on srle_pkg, srle_ifs (channel interfaces) and srle_store.
//
//   Channel   Dir   Beat contents                                   Handshake
//   req_ch    in    rx_byte, rx_error                               valid/ready
//   rsp_ch    out   line_char, line_last, line_empty, line_truncated valid/ready
//
// An editing byte (store, backspace, ignore) is handled in the cycle that accepts it.
// A line end reads each stored character out through the store's registered read
// followed by the load of the output register; an empty line gives a single beat.
// No bytes are taken while a line is being read out. Reset is synchronous and
// clears the count, the overflow flag and the control state; the store holds no
// reset value. A stall on rsp_ch holds the output register and pauses the read-out.
module serial_rx_line_editor_core #(
   parameter int LINE_MAX = srle_pkg::LINE_MAX_DEF
) (
   input  logic        clock,
   input  logic        reset,
   srle_req_if.sink    req_ch,
   srle_rsp_if.source  rsp_ch
);

   localparam int CNT_W  = $clog2(LINE_MAX + 1);
   localparam int ADDR_W = (LINE_MAX > 1) ? $clog2(LINE_MAX) : 1;

   typedef enum logic {ST_IDLE, ST_EMIT} state_type;

   state_type           state_ff, state_in;
   logic [CNT_W-1:0]    count_ff, count_in;
   logic                ovf_ff, ovf_in;
   logic [CNT_W-1:0]    len_ff, len_in;
   logic [CNT_W-1:0]    idx_ff, idx_in;
   logic                trunc_ff, trunc_in;
   logic                pend_ff, pend_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [7:0]          rsp_char_ff, rsp_char_in;
   logic                rsp_last_ff, rsp_last_in;
   logic                rsp_empty_ff, rsp_empty_in;
   logic                rsp_trunc_ff, rsp_trunc_in;

   srle_pkg::store_ctl_type store_ctl;
   logic [ADDR_W-1:0]   rd_addr;
   logic [7:0]          rd_data;
   logic                accept;
   logic                out_free;
   logic                full;

   srle_store #(
      .DEPTH  (LINE_MAX),
      .ADDR_W (ADDR_W)
   ) u_store (
      .clock   (clock),
      .ctl     (store_ctl),
      .wr_addr (count_ff[ADDR_W-1:0]),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign req_ch.ready = (state_ff == ST_IDLE);
   assign accept       = req_ch.valid && req_ch.ready;
   assign out_free     = !rsp_valid_ff || rsp_ch.ready;
   assign full         = (count_ff == CNT_W'(LINE_MAX));
   assign rd_addr      = idx_ff[ADDR_W-1:0];

   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      ovf_in        = ovf_ff;
      len_in        = len_ff;
      idx_in        = idx_ff;
      trunc_in      = trunc_ff;
      pend_in       = pend_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ch.ready;
      rsp_char_in   = rsp_char_ff;
      rsp_last_in   = rsp_last_ff;
      rsp_empty_in  = rsp_empty_ff;
      rsp_trunc_in  = rsp_trunc_ff;
      store_ctl.wr_en   = 1'b0;
      store_ctl.rd_en   = 1'b0;
      store_ctl.wr_data = req_ch.rx_byte;

      case (state_ff)
         ST_IDLE: begin
            if (accept && !req_ch.rx_error) begin
               case (req_ch.rx_byte)
                  srle_pkg::CH_BS: begin
                     if (count_ff != '0) begin
                        count_in = count_ff - CNT_W'(1);
                     end
                  end
                  srle_pkg::CH_CR: begin
                     len_in   = count_ff;
                     trunc_in = ovf_ff;
                     count_in = '0;
                     ovf_in   = 1'b0;
                     idx_in   = '0;
                     state_in = ST_EMIT;
                  end
                  srle_pkg::CH_LF: begin
                  end
                  srle_pkg::CH_NUL: begin
                     // The NUL is written now and read back no earlier than the
                     // next cycle, so the read always sees it.
                     if (!full) begin
                        store_ctl.wr_en = 1'b1;
                        len_in   = count_ff + CNT_W'(1);
                        trunc_in = ovf_ff;
                     end else begin
                        len_in   = count_ff;
                        trunc_in = 1'b1;
                     end
                     count_in = '0;
                     ovf_in   = 1'b0;
                     idx_in   = '0;
                     state_in = ST_EMIT;
                  end
                  default: begin
                     if (srle_pkg::is_printable(req_ch.rx_byte)) begin
                        if (!full) begin
                           store_ctl.wr_en = 1'b1;
                           count_in = count_ff + CNT_W'(1);
                        end else begin
                           ovf_in = 1'b1;
                        end
                     end
                  end
               endcase
            end
         end
         ST_EMIT: begin
            if (pend_ff) begin
               // The output register is known to be empty here: the read was
               // issued only when it was free or being emptied.
               pend_in      = 1'b0;
               rsp_valid_in = 1'b1;
               rsp_char_in  = rd_data;
               rsp_last_in  = (idx_ff == len_ff);
               rsp_empty_in = 1'b0;
               rsp_trunc_in = trunc_ff;
               if (idx_ff == len_ff) begin
                  state_in = ST_IDLE;
               end
            end else if (out_free) begin
               if (len_ff == '0) begin
                  rsp_valid_in = 1'b1;
                  rsp_char_in  = '0;
                  rsp_last_in  = 1'b1;
                  rsp_empty_in = 1'b1;
                  rsp_trunc_in = trunc_ff;
                  state_in     = ST_IDLE;
               end else begin
                  store_ctl.rd_en = 1'b1;
                  idx_in  = idx_ff + CNT_W'(1);
                  pend_in = 1'b1;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         ovf_ff       <= 1'b0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         ovf_ff       <= ovf_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      len_ff       <= len_in;
      idx_ff       <= idx_in;
      trunc_ff     <= trunc_in;
      rsp_char_ff  <= rsp_char_in;
      rsp_last_ff  <= rsp_last_in;
      rsp_empty_ff <= rsp_empty_in;
      rsp_trunc_ff <= rsp_trunc_in;
   end

   assign rsp_ch.valid          = rsp_valid_ff;
   assign rsp_ch.line_char      = rsp_char_ff;
   assign rsp_ch.line_last      = rsp_last_ff;
   assign rsp_ch.line_empty     = rsp_empty_ff;
   assign rsp_ch.line_truncated = rsp_trunc_ff;

endmodule

[bench/tb_serial_rx_line_editor_core.sv]
`timescale 1ns / 1ps
// Self-checking testbench for serial_rx_line_editor_core: drives received bytes and
// checks every line beat against a behavioral line predictor.
// Depends on srle_pkg and the channel interfaces in srle_ifs.
module tb_serial_rx_line_editor_core;

   localparam int LINE_CAP    = srle_pkg::LINE_MAX_DEF;
   localparam int IDX_W       = $clog2(LINE_CAP);
   localparam int CYCLE_LIMIT = 1000000;
   localparam int MAX_REPORTS = 10;
   localparam int PHASE_ITEMS = 18;

   typedef struct packed {
      logic [7:0] ch;
      logic       last;
      logic       empty;
      logic       trunc;
   } line_beat_type;

   logic clock;
   logic reset;

   srle_req_if req_ch ();
   srle_rsp_if rsp_ch ();

   serial_rx_line_editor_core uut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   // Predicted line state.
   logic [7:0] pred_text [LINE_CAP];
   logic [6:0] pred_len;
   logic       pred_overflow;
   line_beat_type pending_beats[$];

   int fault_count;
   int cycle_count;
   int send_idle_pct;
   int rsp_stall_pct;
   int rsp_hold_left;
   int item_count;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("** serial_rx_line_editor_core: FAILED **");
         $finish;
      end
   end

   // Result receiver: random stalls, plus a long hold-off on request.
   initial begin
      rsp_ch.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (rsp_hold_left > 0) begin
            rsp_ch.ready = 1'b0;
            rsp_hold_left--;
         end else begin
            rsp_ch.ready = ($urandom_range(99) >= rsp_stall_pct);
         end
      end
   end

   // Compares each accepted result beat with the oldest predicted one.
   initial begin : line_checker
      line_beat_type want;
      forever begin
         @(posedge clock);
         if (!reset && rsp_ch.valid === 1'b1 && rsp_ch.ready) begin
            if (pending_beats.size() == 0) begin
               fault_count++;
               if (fault_count <= MAX_REPORTS)
                  $display("unexpected beat: char=%h last=%b empty=%b trunc=%b",
                           rsp_ch.line_char, rsp_ch.line_last, rsp_ch.line_empty,
                           rsp_ch.line_truncated);
            end else begin
               want = pending_beats.pop_front();
               if (rsp_ch.line_char !== want.ch || rsp_ch.line_last !== want.last ||
                   rsp_ch.line_empty !== want.empty ||
                   rsp_ch.line_truncated !== want.trunc) begin
                  fault_count++;
                  if (fault_count <= MAX_REPORTS)
                     $display({"beat mismatch: expected char=%h last=%b empty=%b trunc=%b,",
                               " got char=%h last=%b empty=%b trunc=%b"},
                              want.ch, want.last, want.empty, want.trunc,
                              rsp_ch.line_char, rsp_ch.line_last, rsp_ch.line_empty,
                              rsp_ch.line_truncated);
               end
            end
         end
      end
   end

   function automatic logic is_text(input logic [7:0] b);
      return (b >= srle_pkg::PRINT_LO) && (b <= srle_pkg::PRINT_HI);
   endfunction

   task automatic append_char(input logic [7:0] b);
      if (pred_len < LINE_CAP) begin
         pred_text[pred_len[IDX_W-1:0]] = b;
         pred_len++;
      end else begin
         pred_overflow = 1'b1;
      end
   endtask

   task automatic flush_line();
      line_beat_type beat;
      if (pred_len == 0) begin
         beat = '{ch: 8'h00, last: 1'b1, empty: 1'b1, trunc: pred_overflow};
         pending_beats.push_back(beat);
      end else begin
         for (int i = 0; i < pred_len; i++) begin
            beat = '{ch: pred_text[i], last: (i == pred_len - 1), empty: 1'b0,
                     trunc: pred_overflow};
            pending_beats.push_back(beat);
         end
      end
      pred_len      = '0;
      pred_overflow = 1'b0;
   endtask

   task automatic predict_rx(input logic [7:0] b, input logic err);
      if (!err) begin
         if (b == srle_pkg::CH_BS) begin
            if (pred_len != 0)
               pred_len--;
         end else if (b == srle_pkg::CH_CR) begin
            flush_line();
         end else if (b == srle_pkg::CH_NUL) begin
            append_char(b);
            flush_line();
         end else if (is_text(b)) begin
            append_char(b);
         end
      end
   endtask

   // Called and returning just after a falling edge.
   task automatic send_rx(input logic [7:0] b, input logic err);
      while ($urandom_range(99) < send_idle_pct) begin
         req_ch.valid = 1'b0;
         @(negedge clock);
      end
      req_ch.valid    = 1'b1;
      req_ch.rx_byte  = b;
      req_ch.rx_error = err;
      do
         @(posedge clock);
      while (!req_ch.ready);
      predict_rx(b, err);
      item_count++;
      @(negedge clock);
   endtask

   task automatic send_text(input int count);
      for (int i = 0; i < count; i++)
         send_rx(8'($urandom_range(srle_pkg::PRINT_HI, srle_pkg::PRINT_LO)), 1'b0);
   endtask

   task automatic wait_drain();
      req_ch.valid = 1'b0;
      while (pending_beats.size() != 0)
         @(negedge clock);
   endtask

   // Bytes that leave the line alone: errored beats, line feeds, control and high codes.
   task automatic send_noise();
      logic [7:0] b;
      int         pick;
      pick = $urandom_range(99);
      if (pick < 40) begin
         send_rx(8'($urandom_range(255)), 1'b1);
      end else if (pick < 60) begin
         send_rx(srle_pkg::CH_LF, 1'b0);
      end else begin
         do
            b = 8'($urandom_range(255));
         while (is_text(b) || b == srle_pkg::CH_BS || b == srle_pkg::CH_CR ||
                b == srle_pkg::CH_NUL);
         send_rx(b, 1'b0);
      end
   endtask

   task automatic test_dropped_bytes();
      send_rx("A", 1'b1);
      send_rx(srle_pkg::CH_CR, 1'b1);
      send_rx(srle_pkg::CH_NUL, 1'b1);
      send_rx("B", 1'b0);
      send_rx(srle_pkg::CH_BS, 1'b1);
      send_rx(srle_pkg::CH_CR, 1'b0);
   endtask

   task automatic test_empty_line();
      send_rx(srle_pkg::CH_CR, 1'b0);
   endtask

   task automatic test_byte_extremes();
      send_rx(srle_pkg::PRINT_LO, 1'b0);
      send_rx(8'h1F, 1'b0);
      send_rx(8'h7F, 1'b0);
      send_rx(8'hFF, 1'b0);
      send_rx(8'h80, 1'b0);
      send_rx(srle_pkg::CH_LF, 1'b0);
      send_rx(srle_pkg::PRINT_HI, 1'b0);
      send_rx(srle_pkg::CH_CR, 1'b0);
   endtask

   task automatic test_backspace();
      send_rx(srle_pkg::CH_BS, 1'b0);
      send_rx("a", 1'b0);
      send_rx("b", 1'b0);
      send_rx(srle_pkg::CH_BS, 1'b0);
      send_rx("c", 1'b0);
      send_rx(srle_pkg::CH_CR, 1'b0);
      send_rx("z", 1'b0);
      send_rx(srle_pkg::CH_BS, 1'b0);
      send_rx(srle_pkg::CH_CR, 1'b0);
   endtask

   task automatic test_nul_line();
      send_rx(srle_pkg::CH_NUL, 1'b0);
      send_rx("q", 1'b0);
      send_rx(srle_pkg::CH_NUL, 1'b0);
   endtask

   // A full store drops characters and marks the line; backspace keeps the mark,
   // even when it empties the line.
   task automatic test_full_store();
      send_text(LINE_CAP + 1);
      send_rx(srle_pkg::CH_NUL, 1'b0);
      send_text(LINE_CAP + 1);
      for (int i = 0; i < LINE_CAP; i++)
         send_rx(srle_pkg::CH_BS, 1'b0);
      send_rx(srle_pkg::CH_CR, 1'b0);
   endtask

   // The receiver holds off while lines keep coming, so input is stalled by read-out.
   task automatic test_backpressure();
      rsp_hold_left = 400;
      send_text(6);
      send_rx(srle_pkg::CH_CR, 1'b0);
      send_text(3);
      send_rx(srle_pkg::CH_CR, 1'b0);
      send_text(2);
      send_rx(srle_pkg::CH_NUL, 1'b0);
      wait_drain();
   endtask

   task automatic send_random_line();
      int n_chars;
      int pick;
      pick = $urandom_range(99);
      if (pick < 80)
         n_chars = $urandom_range(12, 0);
      else if (pick < 94)
         n_chars = $urandom_range(LINE_CAP - 1, 13);
      else
         n_chars = $urandom_range(LINE_CAP + 6, LINE_CAP);
      for (int i = 0; i < n_chars; i++) begin
         pick = $urandom_range(99);
         if (pick < 7)
            send_noise();
         else if (pick < 12)
            send_rx(srle_pkg::CH_BS, 1'b0);
         send_text(1);
      end
      if ($urandom_range(99) < 5)
         send_rx(srle_pkg::CH_CR, 1'b1);
      if ($urandom_range(99) < 75)
         send_rx(srle_pkg::CH_CR, 1'b0);
      else
         send_rx(srle_pkg::CH_NUL, 1'b0);
   endtask

   task automatic test_random_lines(input int idle_pct, input int stall_pct,
                                    input int n_items);
      int target;
      send_idle_pct = idle_pct;
      rsp_stall_pct = stall_pct;
      target        = item_count + n_items;
      do
         send_random_line();
      while (item_count < target);
      wait_drain();
   endtask

   initial begin
      reset           = 1'b1;
      req_ch.valid    = 1'b0;
      req_ch.rx_byte  = '0;
      req_ch.rx_error = 1'b0;
      pred_len        = '0;
      pred_overflow   = 1'b0;
      fault_count     = 0;
      cycle_count     = 0;
      send_idle_pct   = 0;
      rsp_stall_pct   = 0;
      rsp_hold_left   = 0;
      item_count      = 0;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_dropped_bytes();
      test_empty_line();
      test_byte_extremes();
      test_backspace();
      test_nul_line();
      test_full_store();
      wait_drain();
      test_backpressure();

      test_random_lines(0, 0, PHASE_ITEMS);
      test_random_lines(55, 0, PHASE_ITEMS);
      test_random_lines(0, 55, PHASE_ITEMS);
      test_random_lines(20, 20, PHASE_ITEMS);

      send_idle_pct = 0;
      rsp_stall_pct = 0;
      repeat (200) @(negedge clock);
      if (pending_beats.size() != 0)
         fault_count++;
      if (fault_count == 0)
         $display("** serial_rx_line_editor_core: PASSED **");
      else
         $display("** serial_rx_line_editor_core: FAILED **");
      $finish;
   end

endmodule

[files.f]
hdl/srle_pkg.sv
hdl/srle_ifs.sv
hdl/srle_store.sv
hdl/serial_rx_line_editor_core.sv
bench/tb_serial_rx_line_editor_core.sv
